[hw/rtl/rabq_pkg.sv]
`default_nettype none
package rabq_pkg;
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_TERMINATE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_GRANTED = 3'd0,
		ST_QUEUED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_REFUSED = 3'd3,
		ST_RELEASED = 3'd4,
		ST_TERMINATED = 3'd5,
		ST_LOADED = 3'd6
	} status_t;

	localparam int CmdW = 2;
	localparam int SlotW = 4;
	localparam int ClassW = 5;
	localparam int UnitW = 4;
	localparam int StatusW = 3;
endpackage
`default_nettype wire

[hw/rtl/rabq_ram.sv]
`default_nettype none
module rabq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/resource_allocator_blocked_queue.sv]
// Channel | Dir | tdata fields (low bit up)                   | tuser
// s_axis  | in  | cmd[1:0] slot[5:2] class[10:6] units[14:11] | none
// m_axis  | out | status[2:0] woken_valid[3] woken_slot[7:4]  | none
// Release scans the wait queue in order and wakes the first entry whose request now fits.
// Terminate returns the slot's holdings with one read and one write of the holding table
// per class. After reset a clearing pass over every holding table entry (512 with the default
// sizes) zeroes the table while s_axis_tready stays low. A waiting result holds the block
// until it is taken.
`default_nettype none
module resource_allocator_blocked_queue
	import rabq_pkg::*;
#(
	parameter int NUM_SLOTS = 16,
	parameter int NUM_CLASSES = 32,
	parameter int QUEUE_DEPTH = 16,
	parameter int COUNT_BITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// cmd, slot, resource_class, unit_count, one zero pad bit
	input wire logic [15:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status, woken_valid, woken_slot
	output logic [7:0] m_axis_tdata
);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int HW = SW + CW;
	localparam int HD = 1 << HW;
	localparam int EW = ((COUNT_BITS > UnitW) ? COUNT_BITS : UnitW) + 1;
	localparam logic [EW-1:0] CMAX = EW'((1 << COUNT_BITS) - 1);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_RD = 12'b000000000100,
		S_EXEC = 12'b000000001000,
		S_QSCAN = 12'b000000010000,
		S_QRD = 12'b000000100000,
		S_QCHK = 12'b000001000000,
		S_WRD = 12'b000010000000,
		S_WUPD = 12'b000100000000,
		S_TRD = 12'b001000000000,
		S_TUPD = 12'b010000000000,
		S_OUT = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [CmdW-1:0] cmd_q;
	logic [SlotW-1:0] slot_q;
	logic [ClassW-1:0] cls_q;
	logic [UnitW-1:0] units_q;
	logic [StatusW-1:0] status_q;
	logic wv_q;
	logic [SlotW-1:0] ws_q;
	logic [HW:0] cnt_q;
	logic [QW:0] qi_q;
	logic [CW:0] ci_q;
	logic [QUEUE_DEPTH-1:0] wvalid_q;
	logic [SlotW-1:0] wslot_q [QUEUE_DEPTH];
	logic [ClassW-1:0] wcls_q [QUEUE_DEPTH];
	logic [UnitW-1:0] wunits_q [QUEUE_DEPTH];
	logic [SlotW-1:0] eslot_q;
	logic [ClassW-1:0] ecls_q;
	logic [UnitW-1:0] eunits_q;
	logic [COUNT_BITS-1:0] rem_q [NUM_CLASSES];

	logic h_we;
	logic [HW-1:0] h_waddr, h_raddr;
	logic [COUNT_BITS-1:0] h_wdata, h_rdata;

	rabq_ram #(.Width(COUNT_BITS), .Depth(HD)) u_held (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	logic slot_ok, cls_ok, eok;
	logic [CW-1:0] cidx, ecidx;
	logic [SW-1:0] sidx, esidx;
	logic [QUEUE_DEPTH-1:0] free_v;
	logic free_any;
	logic [QW-1:0] free_i;
	logic [EW-1:0] rem_ext, h_ext, u_ext, eu_ext, erem_ext, sum_a, sum_b, trem_ext;

	assign slot_ok = 32'(slot_q) < NUM_SLOTS;
	assign cls_ok = 32'(cls_q) < NUM_CLASSES;
	assign eok = (32'(eslot_q) < NUM_SLOTS) && (32'(ecls_q) < NUM_CLASSES);
	assign cidx = CW'(cls_q);
	assign sidx = SW'(slot_q);
	assign ecidx = CW'(ecls_q);
	assign esidx = SW'(eslot_q);
	assign rem_ext = EW'(rem_q[cidx]);
	assign erem_ext = EW'(rem_q[ecidx]);
	assign h_ext = EW'(h_rdata);
	assign u_ext = EW'(units_q);
	assign eu_ext = EW'(eunits_q);
	assign trem_ext = EW'(rem_q[ci_q[CW-1:0]]) + h_ext;
	assign free_v = ~wvalid_q;
	assign free_any = |free_v;

	always_comb begin
		free_i = '0;
		for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
			if (free_v[k]) begin
				free_i = QW'(k);
			end
		end
	end

	always_comb begin
		h_we = 1'b0;
		h_waddr = {sidx, cidx};
		h_wdata = '0;
		h_raddr = {sidx, cidx};
		sum_a = h_ext + u_ext;
		sum_b = h_ext + eu_ext;
		unique case (state_q)
			S_CLEAR: begin
				h_we = 1'b1;
				h_waddr = cnt_q[HW-1:0];
			end
			S_EXEC: begin
				if (cmd_q == CMD_REQUEST && slot_ok && cls_ok && rem_ext >= u_ext) begin
					h_we = 1'b1;
					h_wdata = (sum_a > CMAX) ? CMAX[COUNT_BITS-1:0] : sum_a[COUNT_BITS-1:0];
				end else if (cmd_q == CMD_RELEASE && slot_ok && cls_ok && h_ext >= u_ext) begin
					h_we = 1'b1;
					h_wdata = COUNT_BITS'(h_ext - u_ext);
				end
			end
			S_WRD: h_raddr = {esidx, ecidx};
			S_WUPD: begin
				h_we = 1'b1;
				h_waddr = {esidx, ecidx};
				h_wdata = (sum_b > CMAX) ? CMAX[COUNT_BITS-1:0] : sum_b[COUNT_BITS-1:0];
			end
			S_TRD: h_raddr = {sidx, ci_q[CW-1:0]};
			S_TUPD: begin
				h_we = 1'b1;
				h_waddr = {sidx, ci_q[CW-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			wvalid_q <= '0;
			for (int k = 0; k < NUM_CLASSES; k++) rem_q[k] <= '0;
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				wslot_q[k] <= '0;
				wcls_q[k] <= '0;
				wunits_q[k] <= '0;
			end
			qi_q <= '0;
			ci_q <= '0;
			status_q <= '0;
			wv_q <= 1'b0;
			ws_q <= '0;
			eslot_q <= '0;
			ecls_q <= '0;
			eunits_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == HD - 1) state_q <= S_IDLE;
				end
				S_IDLE: if (s_axis_tvalid) state_q <= S_RD;
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					wv_q <= 1'b0;
					ws_q <= '0;
					qi_q <= '0;
					ci_q <= '0;
					state_q <= S_OUT;
					unique case (cmd_q)
						CMD_LOAD: begin
							status_q <= ST_LOADED;
							if (cls_ok) rem_q[cidx] <= (u_ext > CMAX) ? CMAX[COUNT_BITS-1:0]
								: u_ext[COUNT_BITS-1:0];
						end
						CMD_REQUEST: begin
							if (!slot_ok || !cls_ok) status_q <= ST_DROPPED;
							else if (rem_ext >= u_ext) begin
								status_q <= ST_GRANTED;
								rem_q[cidx] <= COUNT_BITS'(rem_ext - u_ext);
							end else if (free_any) begin
								status_q <= ST_QUEUED;
								wvalid_q[free_i] <= 1'b1;
								wslot_q[free_i] <= slot_q;
								wcls_q[free_i] <= cls_q;
								wunits_q[free_i] <= units_q;
							end else status_q <= ST_DROPPED;
						end
						CMD_RELEASE: begin
							state_q <= S_QSCAN;
							if (!slot_ok || !cls_ok || h_ext < u_ext) status_q <= ST_REFUSED;
							else begin
								status_q <= ST_RELEASED;
								rem_q[cidx] <= ((rem_ext + u_ext) > CMAX) ? CMAX[COUNT_BITS-1:0]
									: COUNT_BITS'(rem_ext + u_ext);
							end
						end
						default: begin
							status_q <= ST_TERMINATED;
							if (slot_ok) state_q <= S_TRD;
						end
					endcase
				end
				S_QSCAN: begin
					if (32'(qi_q) == QUEUE_DEPTH) state_q <= S_OUT;
					else state_q <= S_QRD;
				end
				S_QRD: begin
					eslot_q <= wslot_q[qi_q[QW-1:0]];
					ecls_q <= wcls_q[qi_q[QW-1:0]];
					eunits_q <= wunits_q[qi_q[QW-1:0]];
					state_q <= S_QCHK;
				end
				S_QCHK: begin
					if (wvalid_q[qi_q[QW-1:0]] && eok && erem_ext >= eu_ext) begin
						rem_q[ecidx] <= COUNT_BITS'(erem_ext - eu_ext);
						wvalid_q[qi_q[QW-1:0]] <= 1'b0;
						wv_q <= 1'b1;
						ws_q <= eslot_q;
						state_q <= S_WRD;
					end else begin
						qi_q <= qi_q + 1'b1;
						state_q <= S_QSCAN;
					end
				end
				S_WRD: state_q <= S_WUPD;
				S_WUPD: state_q <= S_OUT;
				S_TRD: state_q <= S_TUPD;
				S_TUPD: begin
					rem_q[ci_q[CW-1:0]] <= (trem_ext > CMAX) ? CMAX[COUNT_BITS-1:0]
						: trem_ext[COUNT_BITS-1:0];
					ci_q <= ci_q + 1'b1;
					if (32'(ci_q) == NUM_CLASSES - 1) state_q <= S_OUT;
					else state_q <= S_TRD;
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			cmd_q <= s_axis_tdata[1:0];
			slot_q <= s_axis_tdata[5:2];
			cls_q <= s_axis_tdata[10:6];
			units_q <= s_axis_tdata[14:11];
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {ws_q, wv_q, status_q};

`ifndef ASSERT_OFF
	a_woken_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && wv_q |-> (status_q == ST_RELEASED || status_q == ST_REFUSED))
		else $error("woken reported outside a release");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

[tb/sv/resource_allocator_blocked_queue_tb.sv]
`timescale 1ns / 1ps
module resource_allocator_blocked_queue_tb;
	import rabq_pkg::*;

	localparam int NSLOT = 16;
	localparam int NCLS = 32;
	localparam int QDEPTH = 16;
	localparam logic [3:0] UMAX = 4'hf;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [3:0] units;
		logic [4:0] cls;
		logic [3:0] slot;
		cmd_t cmd;
	} alloc_cmd_t;

	typedef struct packed {
		logic [3:0] woken_slot;
		logic woken_valid;
		status_t status;
	} alloc_resp_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;

	resource_allocator_blocked_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	logic [3:0] remaining [NCLS];
	logic [3:0] held [NSLOT][NCLS];
	logic wq_valid [QDEPTH];
	logic [3:0] wq_slot [QDEPTH];
	logic [4:0] wq_cls [QDEPTH];
	logic [3:0] wq_units [QDEPTH];

	alloc_cmd_t pending_cmds [$];
	alloc_resp_t expected_resps [$];
	int errors;
	int cycles;
	bit stim_done;
	bit sender_pause;
	int hold_off;
	logic in_acc;
	logic out_acc;
	int rx_gap;

	function automatic logic [3:0] sat_sum(logic [3:0] a, logic [3:0] b);
		logic [4:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s > UMAX ? UMAX : s[3:0];
	endfunction

	function automatic alloc_resp_t allocate(alloc_cmd_t c);
		alloc_resp_t r;
		r = '0;
		case (c.cmd)
			CMD_LOAD: begin
				r.status = ST_LOADED;
				remaining[c.cls] = c.units;
			end
			CMD_REQUEST: begin
				if (remaining[c.cls] >= c.units) begin
					remaining[c.cls] = remaining[c.cls] - c.units;
					held[c.slot][c.cls] = sat_sum(held[c.slot][c.cls], c.units);
					r.status = ST_GRANTED;
				end else begin
					r.status = ST_DROPPED;
					for (int i = 0; i < QDEPTH; i++) begin
						if (!wq_valid[i]) begin
							wq_valid[i] = 1'b1;
							wq_slot[i] = c.slot;
							wq_cls[i] = c.cls;
							wq_units[i] = c.units;
							r.status = ST_QUEUED;
							break;
						end
					end
				end
			end
			CMD_RELEASE: begin
				if (held[c.slot][c.cls] < c.units) begin
					r.status = ST_REFUSED;
				end else begin
					held[c.slot][c.cls] = held[c.slot][c.cls] - c.units;
					remaining[c.cls] = sat_sum(remaining[c.cls], c.units);
					r.status = ST_RELEASED;
				end
				for (int i = 0; i < QDEPTH; i++) begin
					if (wq_valid[i] && remaining[wq_cls[i]] >= wq_units[i]) begin
						remaining[wq_cls[i]] = remaining[wq_cls[i]] - wq_units[i];
						held[wq_slot[i]][wq_cls[i]] =
							sat_sum(held[wq_slot[i]][wq_cls[i]], wq_units[i]);
						wq_valid[i] = 1'b0;
						r.woken_valid = 1'b1;
						r.woken_slot = wq_slot[i];
						break;
					end
				end
			end
			default: begin
				r.status = ST_TERMINATED;
				for (int j = 0; j < NCLS; j++) begin
					remaining[j] = sat_sum(remaining[j], held[c.slot][j]);
					held[c.slot][j] = '0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic alloc_cmd_t make_cmd(cmd_t op, int s, int k, int u);
		alloc_cmd_t c;
		c.cmd = op;
		c.slot = s[3:0];
		c.cls = k[4:0];
		c.units = u[3:0];
		return c;
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		int hot;
		int r;
		cmd_t op;
		errors = 0;
		stim_done = 0;
		sender_pause = 0;
		hold_off = 0;
		for (int k = 0; k < NCLS; k++) remaining[k] = '0;
		for (int s = 0; s < NSLOT; s++)
			for (int k = 0; k < NCLS; k++) held[s][k] = '0;
		for (int i = 0; i < QDEPTH; i++) wq_valid[i] = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_cmds.push_back(make_cmd(CMD_LOAD, 0, 0, 15));
		pending_cmds.push_back(make_cmd(CMD_LOAD, 15, 31, 0));
		pending_cmds.push_back(make_cmd(CMD_REQUEST, 0, 0, 15));
		pending_cmds.push_back(make_cmd(CMD_REQUEST, 15, 31, 0));
		pending_cmds.push_back(make_cmd(CMD_REQUEST, 3, 31, 15));
		pending_cmds.push_back(make_cmd(CMD_REQUEST, 4, 0, 1));
		pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 15));
		pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 15));
		pending_cmds.push_back(make_cmd(CMD_RELEASE, 15, 31, 0));
		pending_cmds.push_back(make_cmd(CMD_LOAD, 5, 7, 15));
		pending_cmds.push_back(make_cmd(CMD_REQUEST, 2, 7, 15));
		pending_cmds.push_back(make_cmd(CMD_LOAD, 5, 7, 15));
		pending_cmds.push_back(make_cmd(CMD_RELEASE, 2, 7, 15));
		pending_cmds.push_back(make_cmd(CMD_TERMINATE, 2, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_TERMINATE, 4, 0, 0));
		for (int i = 0; i < 17; i++)
			pending_cmds.push_back(make_cmd(CMD_REQUEST, i % 16, 9, 15));
		pending_cmds.push_back(make_cmd(CMD_TERMINATE, 15, 0, 0));
		wait (pending_cmds.size() == 0 && expected_resps.size() == 0);

		hold_off = 400;
		for (int n = 0; n < 1800; n++) begin
			if (n == 900) begin
				wait (pending_cmds.size() == 0);
				sender_pause = 1;
				wait (expected_resps.size() == 0);
				sender_pause = 0;
			end
			hot = $urandom_range(0, 3);
			r = $urandom_range(0, 99);
			op = r < 15 ? CMD_LOAD : r < 50 ? CMD_REQUEST : r < 92 ? CMD_RELEASE : CMD_TERMINATE;
			pending_cmds.push_back(make_cmd(op, $urandom_range(0, 15),
				(r & 1) ? hot : $urandom_range(0, 31),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5)));
			if (pending_cmds.size() > 8) wait (pending_cmds.size() <= 4);
		end
		wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
		repeat (100) @(posedge clk);
		stim_done = 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_acc <= 1'b0;
			out_acc <= 1'b0;
		end else begin
			in_acc <= s_axis_tvalid && s_axis_tready;
			out_acc <= m_axis_tvalid && m_axis_tready;
		end
	end

	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else if (s_axis_tvalid && !in_acc) begin
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_cmds.size() > 0 && !sender_pause) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {1'b0, pending_cmds[0]};
			expected_resps.push_back(allocate(pending_cmds[0]));
			void'(pending_cmds.pop_front());
			send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap <= 0;
		end else if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (out_acc) begin
			g = $urandom_range(0, 8);
			m_axis_tready <= (g == 0);
			rx_gap <= (g == 0) ? 0 : g - 1;
		end else if (rx_gap > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alloc_resp_t got;
		alloc_resp_t want;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				got = alloc_resp_t'(m_axis_tdata);
				if (expected_resps.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, got);
					errors = errors + 1;
				end else begin
					want = expected_resps.pop_front();
					if (got.status != want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							got.status);
						errors = errors + 1;
					end
					if (got.woken_valid != want.woken_valid) begin
						$display("%0t: woken_valid expected %0d actual %0d", $time,
							want.woken_valid, got.woken_valid);
						errors = errors + 1;
					end
					if (got.woken_slot != want.woken_slot) begin
						$display("%0t: woken_slot expected %0d actual %0d", $time,
							want.woken_slot, got.woken_slot);
						errors = errors + 1;
					end
				end
			end
		end else begin
			cycles <= 0;
		end
	end

	initial begin
		wait (stim_done || cycles >= CYCLE_LIMIT);
		if (stim_done && expected_resps.size() == 0 && errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
